[sv/xmt_pkg.sv]
`timescale 1ns / 1ps

package xmt_pkg;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // byte roles
    localparam logic [2:0] ROLE_SKIP  = 3'd0;
    localparam logic [2:0] ROLE_NAME  = 3'd1;
    localparam logic [2:0] ROLE_ATTR  = 3'd2;
    localparam logic [2:0] ROLE_VALUE = 3'd3;
    localparam logic [2:0] ROLE_TEXT  = 3'd4;

    // field end markers
    localparam logic [1:0] FD_NONE  = 2'd0;
    localparam logic [1:0] FD_NAME  = 2'd1;
    localparam logic [1:0] FD_ATTR  = 2'd2;
    localparam logic [1:0] FD_VALUE = 2'd3;

    // completed tag kinds
    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_SELF  = 2'd2;
    localparam logic [1:0] KIND_PI    = 2'd3;

    // syntax error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_LT_IN_TAG  = 4'd1;
    localparam logic [3:0] ERR_GT_OUTSIDE = 4'd2;
    localparam logic [3:0] ERR_LEAD_TEXT  = 4'd3;
    localparam logic [3:0] ERR_DOC_END    = 4'd4;
    localparam logic [3:0] ERR_EQ         = 4'd5;
    localparam logic [3:0] ERR_QUOTE      = 4'd6;
    localparam logic [3:0] ERR_SLASH      = 4'd7;
    localparam logic [3:0] ERR_QMARK      = 4'd8;
    localparam logic [3:0] ERR_EXP_VALUE  = 4'd9;
    localparam logic [3:0] ERR_TAG_PHASE  = 4'd10;
    localparam logic [3:0] ERR_PI_OPEN    = 4'd11;
    localparam logic [3:0] ERR_EQ_PENDING = 4'd12;

    // control from the outer splitter to the tag state machine
    typedef struct packed {
        logic apply;    // tag content byte taken
        logic restart;  // '<' opens a new tag
        logic flush;    // final byte of the document
    } xmt_tag_ctl_t;

    // per-byte decode of the tag state machine
    typedef struct packed {
        logic [2:0] role;
        logic [1:0] field_done;
        logic       tag_done;
        logic [1:0] tag_kind;
        logic [3:0] err;
    } xmt_tag_res_t;

endpackage

[sv/xml_markup_byte_tokenizer.sv]
`timescale 1ns / 1ps

// byte stream markup tokenizer, one document byte per transaction
// pipeline: input register, then result register
// throughput: one byte per cycle unless m_ready stalls a full result register, set by the single-pass
//   next-state logic of the splitter and tag state machine between the input and result registers
// reset: synchronous active-low aresetn clears both registers' valid bits and all tokenizer state;
//   the state also returns to reset after each byte marked doc_last

module xml_markup_byte_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_doc_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_echo_byte,
    output logic [2:0] m_role,
    output logic [1:0] m_field_done,
    output logic       m_tag_done,
    output logic [1:0] m_tag_kind,
    output logic [3:0] m_error_code,
    output logic       m_doc_done
);

    typedef enum logic [1:0] {
        OUT_START = 2'd0,
        OUT_TAG   = 2'd1,
        OUT_TEXT  = 2'd2
    } outer_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    outer_t     outer_reg;
    outer_t     outer_next;
    logic       hold_reg;
    logic       hold_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_role_reg;
    logic [1:0] out_fd_reg;
    logic       out_td_reg;
    logic [1:0] out_kind_reg;
    logic [3:0] out_err_reg;
    logic       out_last_reg;

    logic [2:0] cur_role;
    logic [1:0] cur_fd;
    logic       cur_td;
    logic [1:0] cur_kind;
    logic [3:0] cur_err;
    logic       is_ws;

    xmt_pkg::xmt_tag_ctl_t tag_ctl;
    xmt_pkg::xmt_tag_res_t tag_res;

    // the result register frees a slot whenever it is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_data_byte;
                in_last_reg  <= s_doc_last;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    xmt_tag_fsm u_tag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (in_byte_reg),
        .ctl       (tag_ctl),
        .res       (tag_res)
    );

    assign is_ws = (in_byte_reg == xmt_pkg::CH_TAB) || (in_byte_reg == xmt_pkg::CH_LF) ||
                   (in_byte_reg == xmt_pkg::CH_CR);

    // outer splitter and result decode
    always_comb begin
        cur_role        = xmt_pkg::ROLE_SKIP;
        cur_fd          = xmt_pkg::FD_NONE;
        cur_td          = 1'b0;
        cur_kind        = xmt_pkg::KIND_OPEN;
        cur_err         = xmt_pkg::ERR_NONE;
        outer_next      = outer_reg;
        hold_next       = hold_reg;
        tag_ctl         = '0;
        if (!hold_reg) begin
            if (!is_ws) begin
                unique case (outer_reg)
                    OUT_TAG: begin
                        if (in_byte_reg == xmt_pkg::CH_LT) begin
                            cur_err = xmt_pkg::ERR_LT_IN_TAG;
                        end else if (in_byte_reg == xmt_pkg::CH_GT) begin
                            cur_fd   = tag_res.field_done;
                            cur_td   = tag_res.tag_done;
                            cur_kind = tag_res.tag_kind;
                            cur_err  = tag_res.err;
                            if (tag_res.err == xmt_pkg::ERR_NONE) begin
                                outer_next = OUT_TEXT;
                            end
                        end else begin
                            cur_role      = tag_res.role;
                            cur_fd        = tag_res.field_done;
                            cur_err       = tag_res.err;
                            tag_ctl.apply = 1'b1;
                        end
                    end
                    OUT_TEXT: begin
                        if (in_byte_reg == xmt_pkg::CH_LT) begin
                            outer_next      = OUT_TAG;
                            tag_ctl.restart = 1'b1;
                        end else if (in_byte_reg == xmt_pkg::CH_GT) begin
                            cur_err = xmt_pkg::ERR_GT_OUTSIDE;
                        end else begin
                            cur_role = xmt_pkg::ROLE_TEXT;
                        end
                    end
                    default: begin
                        // before the first tag
                        if (in_byte_reg == xmt_pkg::CH_LT) begin
                            outer_next      = OUT_TAG;
                            tag_ctl.restart = 1'b1;
                        end else if (in_byte_reg == xmt_pkg::CH_GT) begin
                            cur_err = xmt_pkg::ERR_GT_OUTSIDE;
                        end else if (in_byte_reg != xmt_pkg::CH_SPACE) begin
                            cur_err = xmt_pkg::ERR_LEAD_TEXT;
                        end
                    end
                endcase
            end
            if (cur_err == xmt_pkg::ERR_NONE && in_last_reg && outer_next != OUT_TEXT) begin
                cur_err = xmt_pkg::ERR_DOC_END;
            end
            if (cur_err != xmt_pkg::ERR_NONE) begin
                hold_next = 1'b1;
                cur_role  = xmt_pkg::ROLE_SKIP;
                cur_fd    = xmt_pkg::FD_NONE;
                cur_td    = 1'b0;
                cur_kind  = xmt_pkg::KIND_OPEN;
            end
        end
        if (in_last_reg) begin
            outer_next    = OUT_START;
            hold_next     = 1'b0;
            tag_ctl.flush = 1'b1;
        end
        tag_ctl.apply   = tag_ctl.apply && advance;
        tag_ctl.restart = tag_ctl.restart && advance;
        tag_ctl.flush   = tag_ctl.flush && advance;
    end

    // splitter state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_reg     <= OUT_START;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                outer_reg     <= outer_next;
                hold_reg      <= hold_next;
                out_valid_reg <= 1'b1;
                out_byte_reg  <= in_byte_reg;
                out_role_reg  <= cur_role;
                out_fd_reg    <= cur_fd;
                out_td_reg    <= cur_td;
                out_kind_reg  <= cur_kind;
                out_err_reg   <= cur_err;
                out_last_reg  <= in_last_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_echo_byte  = out_byte_reg;
    assign m_role       = out_role_reg;
    assign m_field_done = out_fd_reg;
    assign m_tag_done   = out_td_reg;
    assign m_tag_kind   = out_kind_reg;
    assign m_error_code = out_err_reg;
    assign m_doc_done   = out_last_reg;

`ifndef SYNTHESIS
    // a byte that reports an error carries no token information
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_err_reg != xmt_pkg::ERR_NONE |->
            out_role_reg == xmt_pkg::ROLE_SKIP && out_fd_reg == xmt_pkg::FD_NONE &&
            !out_td_reg && out_kind_reg == xmt_pkg::KIND_OPEN)
        else $error("error byte carries token data");

    // tag kind is only reported with a completed tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_td_reg |-> out_kind_reg == xmt_pkg::KIND_OPEN)
        else $error("tag kind without tag end");

    // while an error is held, bytes pass silently
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && hold_reg |-> cur_err == xmt_pkg::ERR_NONE && cur_role == xmt_pkg::ROLE_SKIP)
        else $error("output while error held");

    // the final byte returns the splitter to its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> !hold_reg && outer_reg == OUT_START)
        else $error("state not cleared after final byte");
`endif

endmodule

[sv/xmt_tag_fsm.sv]
`timescale 1ns / 1ps

module xmt_tag_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           data_byte,
    input  xmt_pkg::xmt_tag_ctl_t ctl,
    output xmt_pkg::xmt_tag_res_t res
);

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_NAME     = 3'd1,
        PH_EXP_ATTR = 3'd2,
        PH_ATTR     = 3'd3,
        PH_EXP_VAL  = 3'd4,
        PH_VAL      = 3'd5
    } phase_t;

    // flag bit positions
    localparam int F_PROC  = 0;
    localparam int F_EQ    = 1;
    localparam int F_CLOSE = 2;
    localparam int F_SELF  = 3;
    localparam int F_PI    = 4;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_step;
    logic [4:0] flags_reg;
    logic [4:0] flags_next;
    logic [4:0] flags_step;

    // decode of one tag byte against the current phase and flags
    always_comb begin
        res        = '0;
        phase_step = phase_reg;
        flags_step = flags_reg;
        case (data_byte)
            xmt_pkg::CH_GT: begin
                if (phase_reg == PH_NAME) begin
                    if (!flags_reg[F_PI] && !flags_reg[F_SELF]) begin
                        res.field_done = xmt_pkg::FD_NAME;
                    end
                end else if (phase_reg != PH_EXP_ATTR) begin
                    res.err = xmt_pkg::ERR_TAG_PHASE;
                end
                if (res.err == xmt_pkg::ERR_NONE) begin
                    if (flags_reg[F_PROC]) begin
                        res.err = xmt_pkg::ERR_PI_OPEN;
                    end else if (flags_reg[F_EQ]) begin
                        res.err = xmt_pkg::ERR_EQ_PENDING;
                    end else begin
                        res.tag_done = 1'b1;
                        if (flags_reg[F_CLOSE]) begin
                            res.tag_kind = xmt_pkg::KIND_CLOSE;
                        end else if (flags_reg[F_SELF]) begin
                            res.tag_kind = xmt_pkg::KIND_SELF;
                        end else if (flags_reg[F_PI]) begin
                            res.tag_kind = xmt_pkg::KIND_PI;
                        end else begin
                            res.tag_kind = xmt_pkg::KIND_OPEN;
                        end
                    end
                end
            end
            xmt_pkg::CH_SPACE: begin
                if (phase_reg == PH_NAME) begin
                    phase_step     = PH_EXP_ATTR;
                    res.field_done = xmt_pkg::FD_NAME;
                end else if (phase_reg == PH_ATTR) begin
                    phase_step     = PH_EXP_VAL;
                    res.field_done = xmt_pkg::FD_ATTR;
                end else if (phase_reg == PH_VAL) begin
                    res.role = xmt_pkg::ROLE_VALUE;
                end
            end
            xmt_pkg::CH_EQ: begin
                if (phase_reg == PH_ATTR) begin
                    phase_step       = PH_EXP_VAL;
                    flags_step[F_EQ] = 1'b1;
                    res.field_done   = xmt_pkg::FD_ATTR;
                end else if (phase_reg == PH_VAL) begin
                    res.role = xmt_pkg::ROLE_VALUE;
                end else if (phase_reg == PH_EXP_VAL && !flags_reg[F_EQ]) begin
                    flags_step[F_EQ] = 1'b1;
                end else begin
                    res.err = xmt_pkg::ERR_EQ;
                end
            end
            xmt_pkg::CH_QUOTE: begin
                if (phase_reg == PH_EXP_VAL && flags_reg[F_EQ]) begin
                    phase_step = PH_VAL;
                end else if (phase_reg == PH_VAL && flags_reg[F_EQ]) begin
                    phase_step       = PH_EXP_ATTR;
                    flags_step[F_EQ] = 1'b0;
                    res.field_done   = xmt_pkg::FD_VALUE;
                end else begin
                    res.err = xmt_pkg::ERR_QUOTE;
                end
            end
            xmt_pkg::CH_SLASH: begin
                if (phase_reg == PH_START) begin
                    flags_step[F_CLOSE] = 1'b1;
                end else if (phase_reg == PH_VAL) begin
                    res.role = xmt_pkg::ROLE_VALUE;
                end else if ((phase_reg == PH_NAME || phase_reg == PH_EXP_ATTR) &&
                             !flags_reg[F_SELF] && !flags_reg[F_PROC] &&
                             !flags_reg[F_CLOSE]) begin
                    flags_step[F_SELF] = 1'b1;
                    if (phase_reg == PH_NAME) begin
                        res.field_done = xmt_pkg::FD_NAME;
                    end
                end else begin
                    res.err = xmt_pkg::ERR_SLASH;
                end
            end
            xmt_pkg::CH_QMARK: begin
                if (phase_reg == PH_START) begin
                    flags_step[F_PROC] = 1'b1;
                end else if (phase_reg == PH_VAL) begin
                    res.role = xmt_pkg::ROLE_VALUE;
                end else if ((phase_reg == PH_NAME || phase_reg == PH_EXP_ATTR) &&
                             flags_reg[F_PROC] && !flags_reg[F_SELF]) begin
                    flags_step[F_PI]   = 1'b1;
                    flags_step[F_PROC] = 1'b0;
                    if (phase_reg == PH_NAME) begin
                        res.field_done = xmt_pkg::FD_NAME;
                    end
                end else begin
                    res.err = xmt_pkg::ERR_QMARK;
                end
            end
            default: begin
                // plain name or value character
                if (phase_reg == PH_START) begin
                    phase_step = PH_NAME;
                    res.role   = xmt_pkg::ROLE_NAME;
                end else if (phase_reg == PH_EXP_ATTR) begin
                    phase_step = PH_ATTR;
                    res.role   = xmt_pkg::ROLE_ATTR;
                end else if (phase_reg == PH_NAME) begin
                    res.role = xmt_pkg::ROLE_NAME;
                end else if (phase_reg == PH_ATTR) begin
                    res.role = xmt_pkg::ROLE_ATTR;
                end else if (phase_reg == PH_VAL) begin
                    res.role = xmt_pkg::ROLE_VALUE;
                end else begin
                    res.err = xmt_pkg::ERR_EXP_VALUE;
                end
            end
        endcase
    end

    // next tag state
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        if (ctl.flush || ctl.restart) begin
            phase_next = PH_START;
            flags_next = '0;
        end else if (ctl.apply && res.err == xmt_pkg::ERR_NONE) begin
            phase_next = phase_step;
            flags_next = flags_step;
        end
    end

    // tag state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
        end
    end

`ifndef SYNTHESIS
    // a new tag always starts clean
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.restart || ctl.flush |=> phase_reg == PH_START && flags_reg == '0)
        else $error("tag state not cleared");

    // a closing tag never also carries the self-closing mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg[F_CLOSE] |-> !flags_reg[F_SELF])
        else $error("conflicting tag flags");

    // the '=' flag only lives while a value is expected or being read
    assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg[F_EQ] |-> phase_reg == PH_EXP_VAL || phase_reg == PH_VAL)
        else $error("stray equals flag");
`endif

endmodule
